[sv/swfd_pkg.sv]
// Shared types and constants for the sync word frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package swfd_pkg;

  // Reset value of the sync word register.
  localparam logic [31:0] SYNC_WORD_RST = 32'hCA5E_CA5E;

  // Bytes in the sync word, and header byte positions.
  localparam int unsigned SYNC_BYTES = 4;
  localparam int unsigned IDX_SEQ_LO = 4;
  localparam int unsigned IDX_SEQ_HI = 7;
  localparam int unsigned IDX_TIME_LO = 8;
  localparam int unsigned IDX_TIME_HI = 11;
  localparam int unsigned IDX_CODEC = 12;
  localparam int unsigned IDX_FRONT = 13;
  localparam int unsigned IDX_WIDTH_LO = 14;
  localparam int unsigned IDX_WIDTH_HI = 15;
  localparam int unsigned IDX_HEIGHT_LO = 16;
  localparam int unsigned IDX_HEIGHT_HI = 17;
  localparam int unsigned IDX_LEN_LO = 20;
  localparam int unsigned IDX_LEN_HI = 23;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] sequence_res;
    logic [31:0] timestamp;
    logic [7:0]  codec;
    logic        front_flag;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  // Handoff from the parser to the result register.
  typedef struct packed {
    logic load;   // transfer produced a result this cycle
    logic busy;   // result register full and stalled
  } res_ctrl_t;

endpackage

`default_nettype wire

[sv/swfd_intf.sv]
// Channel interfaces: input byte, result and sync word write.
`timescale 1ns / 1ps
`default_nettype none

interface swfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface swfd_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] sequence_res;
  logic [31:0] timestamp;
  logic [7:0]  codec;
  logic        front_flag;
  logic [15:0] width;
  logic [15:0] height;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (
    output valid, output kind, output sequence_res, output timestamp, output codec,
    output front_flag, output width, output height, output payload_length,
    output payload_byte, output last, input ready
  );
  modport sink (
    input valid, input kind, input sequence_res, input timestamp, input codec,
    input front_flag, input width, input height, input payload_length,
    input payload_byte, input last, output ready
  );
endinterface

interface swfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] sync_word;

  modport source (output valid, output sync_word, input ready);
  modport sink (input valid, input sync_word, output ready);
endinterface

`default_nettype wire

[sv/swfd_parse.sv]
// Frame parser: sync hunt, header capture and payload count.
`timescale 1ns / 1ps
`default_nettype none

module swfd_parse #(
  parameter int unsigned HEADER_BYTES = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        data_byte_i,
  output      logic              in_ready_o,
  input  wire logic [31:0]       sync_word_i,
  input  wire logic              res_busy_i,
  output      swfd_pkg::res_ctrl_t ctrl_o,
  output      swfd_pkg::result_t res_o
);
  import swfd_pkg::*;

  localparam int unsigned CntW = $clog2(HEADER_BYTES);
  localparam logic [CntW-1:0] LastIdx = CntW'(HEADER_BYTES - 1);
  localparam logic [CntW-1:0] SyncCnt = CntW'(SYNC_BYTES);

  phase_e         phase_q, phase_d;
  logic [31:0]    window_q, window_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]    seq_q, seq_d;
  logic [31:0]    time_q, time_d;
  logic [7:0]     codec_q, codec_d;
  logic           front_q, front_d;
  logic [15:0]    width_q, width_d;
  logic [15:0]    height_q, height_d;
  logic [31:0]    len_q, len_d;
  logic [31:0]    remain_q, remain_d;

  logic emit;
  logic accept;

  // A result comes from a payload byte or from the final header byte.
  always_comb begin
    unique case (phase_q)
      PH_PAYLOAD: emit = 1'b1;
      PH_HEADER:  emit = (cnt_q == LastIdx);
      default:    emit = 1'b0;
    endcase
  end

  assign in_ready_o = !res_busy_i || !emit;
  assign accept     = in_valid_i && in_ready_o;
  assign ctrl_o.load = accept && emit;
  assign ctrl_o.busy = res_busy_i;

  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    cnt_d    = cnt_q;
    seq_d    = seq_q;
    time_d   = time_q;
    codec_d  = codec_q;
    front_d  = front_q;
    width_d  = width_q;
    height_d = height_q;
    len_d    = len_q;
    remain_d = remain_q;
    res_o    = '0;

    unique case (phase_q)
      PH_PAYLOAD: begin
        res_o.kind         = KIND_PAYLOAD;
        res_o.payload_byte = data_byte_i;
        res_o.last         = (remain_q == 32'd1);
        remain_d           = remain_q - 32'd1;
        if (remain_q == 32'd1) begin
          phase_d  = PH_HUNT;
          window_d = '0;
          cnt_d    = '0;
        end
      end
      PH_HEADER: begin
        if (cnt_q >= CntW'(IDX_SEQ_LO) && cnt_q <= CntW'(IDX_SEQ_HI)) begin
          seq_d = {seq_q[23:0], data_byte_i};
        end else if (cnt_q >= CntW'(IDX_TIME_LO) && cnt_q <= CntW'(IDX_TIME_HI)) begin
          time_d = {time_q[23:0], data_byte_i};
        end else if (cnt_q == CntW'(IDX_CODEC)) begin
          codec_d = data_byte_i;
        end else if (cnt_q == CntW'(IDX_FRONT)) begin
          front_d = (data_byte_i == 8'd1);
        end else if (cnt_q == CntW'(IDX_WIDTH_LO) || cnt_q == CntW'(IDX_WIDTH_HI)) begin
          width_d = {width_q[7:0], data_byte_i};
        end else if (cnt_q == CntW'(IDX_HEIGHT_LO) || cnt_q == CntW'(IDX_HEIGHT_HI)) begin
          height_d = {height_q[7:0], data_byte_i};
        end else if (cnt_q >= CntW'(IDX_LEN_LO) && cnt_q <= CntW'(IDX_LEN_HI)) begin
          len_d = {len_q[23:0], data_byte_i};
        end

        res_o.kind           = KIND_HEADER;
        res_o.sequence_res   = seq_d;
        res_o.timestamp      = time_d;
        res_o.codec          = codec_d;
        res_o.front_flag     = front_d;
        res_o.width          = width_d;
        res_o.height         = height_d;
        res_o.payload_length = len_d;
        res_o.last           = (len_d == 32'd0);

        if (cnt_q != LastIdx) begin
          cnt_d = cnt_q + CntW'(1);
        end else if (len_d == 32'd0) begin
          phase_d  = PH_HUNT;
          window_d = '0;
          cnt_d    = '0;
        end else begin
          phase_d  = PH_PAYLOAD;
          remain_d = len_d;
          cnt_d    = '0;
        end
      end
      default: begin
        // Hunting; the spare phase code behaves the same.
        window_d = {window_q[23:0], data_byte_i};
        if (cnt_q < SyncCnt) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (cnt_d == SyncCnt && window_d == sync_word_i) begin
          phase_d = PH_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      window_q <= '0;
      cnt_q    <= '0;
      seq_q    <= '0;
      time_q   <= '0;
      codec_q  <= '0;
      front_q  <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      len_q    <= '0;
      remain_q <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      window_q <= window_d;
      cnt_q    <= cnt_d;
      seq_q    <= seq_d;
      time_q   <= time_d;
      codec_q  <= codec_d;
      front_q  <= front_d;
      width_q  <= width_d;
      height_q <= height_d;
      len_q    <= len_d;
      remain_q <= remain_d;
    end
  end

endmodule

`default_nettype wire

[sv/swfd_res_reg.sv]
// Result output register with valid/ready hold.
`timescale 1ns / 1ps
`default_nettype none

module swfd_res_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire swfd_pkg::res_ctrl_t ctrl_i,
  input  wire swfd_pkg::result_t   res_i,
  input  wire logic                out_ready_i,
  output      logic                out_valid_o,
  output      logic                busy_o,
  output      swfd_pkg::result_t   res_o
);
  import swfd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Parser only loads when the register is empty or being drained.
  always_comb begin
    if (ctrl_i.load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && !ctrl_i.busy) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign busy_o      = valid_q && !out_ready_i;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[sv/sync_word_frame_deframer_top.sv]
// Top level of the sync word frame deframer.
//
//   channel   dir  modport  payload                              notes
//   byte_i    in   sink     data_byte[7:0]                       one stream byte per transfer
//   result_o  out  source   kind, header metadata, payload_byte  header or payload result
//   cfg_i     in   sink     sync_word[31:0]                      always ready
//
// One byte per cycle unless result_o stalls: bytes pass through one level of compare,
// shift and count logic into the parser state and the result register.
// A byte that yields a result sets result_o.valid in the cycle after it is taken.
// rst_ni (async, active low) restarts the hunt and loads sync_word 0xCA5ECA5E.
// When result_o stalls, byte_i still takes bytes that produce no result
// (hunting, early header bytes); a result-producing byte waits for room.
// No clearing pass after reset; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module sync_word_frame_deframer_top #(
  parameter int unsigned HEADER_BYTES = 24
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  swfd_byte_if.sink     byte_i,
  swfd_result_if.source result_o,
  swfd_cfg_if.sink      cfg_i
);
  import swfd_pkg::*;

  logic [31:0] sync_word_q;
  res_ctrl_t   ctrl;
  result_t     res_next;
  result_t     res_out;
  logic        res_busy;

  // Sync word: write only while idle (not enforced); takes effect on the next compare.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= SYNC_WORD_RST;
    end else if (cfg_i.valid) begin
      sync_word_q <= cfg_i.sync_word;
    end
  end

  swfd_parse #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_i.valid),
    .data_byte_i (byte_i.data_byte),
    .in_ready_o  (byte_i.ready),
    .sync_word_i (sync_word_q),
    .res_busy_i  (res_busy),
    .ctrl_o      (ctrl),
    .res_o       (res_next)
  );

  swfd_res_reg u_res_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .res_i       (res_next),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .busy_o      (res_busy),
    .res_o       (res_out)
  );

  assign result_o.kind           = res_out.kind;
  assign result_o.sequence_res   = res_out.sequence_res;
  assign result_o.timestamp      = res_out.timestamp;
  assign result_o.codec          = res_out.codec;
  assign result_o.front_flag     = res_out.front_flag;
  assign result_o.width          = res_out.width;
  assign result_o.height         = res_out.height;
  assign result_o.payload_length = res_out.payload_length;
  assign result_o.payload_byte   = res_out.payload_byte;
  assign result_o.last           = res_out.last;

endmodule

`default_nettype wire
